FILE: hw/rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
// Holds the transaction payload structs, mode codes and operation classes.
// No dependencies.
package cau_pkg;

  localparam int WORD_BITS = 32;
  localparam int MODE_BITS = 3;

  localparam logic [MODE_BITS-1:0] MODE_ADD = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_SUB = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_MUL = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_DIV = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_EQ  = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_NE  = 3'd5;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_CMP,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    word_t                a_real;
    word_t                a_imag;
    word_t                b_real;
    word_t                b_imag;
  } in_item_t;

  typedef struct packed {
    word_t res_real;
    word_t res_imag;
    logic  compare_true;
    logic  divide_by_zero;
    logic  saturated;
  } out_item_t;

  typedef struct packed {
    op_t   op;
    logic  cmp;
    word_t a_real;
    word_t a_imag;
    word_t b_real;
    word_t b_imag;
  } cmd_t;

endpackage

FILE: hw/rtl/complex_arith_unit_top.sv
// Top level of the complex arithmetic unit: front part, back pipeline
// and result queue. Depends on cau_pkg, cau_front, cau_back and cau_fifo.
//
//   channel | ports                        | transaction moves on
//   input   | in_push, in_full, in_data    | in_push & !in_full
//   result  | out_pop, out_empty, out_data | out_pop & !out_empty
//
// One transaction is accepted per cycle while in_full is low; results come out in order.
// Every mode passes through the whole divider pipeline, which retires
// one quotient bit per pipeline stage for divides.
// The back pipeline halts as a whole while its last stage holds a result
// and the result queue is full; the command queue then fills and in_full rises.
// Reset is synchronous, active low, and empties all queues and stages.
module complex_arith_unit_top import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  input  in_item_t  in_data,
  output logic      in_full,
  input  logic      out_pop,
  output out_item_t out_data,
  output logic      out_empty
);

  localparam int OUT_DEPTH = 2;

  logic      cmd_vld, cmd_take, res_vld, res_full;
  cmd_t      cmd;
  out_item_t res;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .res_vld  (res_vld),
    .res      (res),
    .res_full (res_full)
  );

  cau_fifo #(.T(out_item_t), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_vld),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_data),
    .empty (out_empty)
  );

endmodule

FILE: hw/rtl/cau_fifo.sv
// Small register queue with push/full and pop/empty sides.
// Used between the front and back parts and on the result side.
// Depends on nothing but its type parameter.
module cau_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  assign wp_nxt  = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
  assign rp_nxt  = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
  assign cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= wp_nxt;
      end
      if (do_pop) begin
        rp_r <= rp_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

FILE: hw/rtl/cau_front.sv
// Front part: accepts input transactions, classifies the mode and
// resolves compares, then queues commands for the back part.
// Depends on cau_pkg and cau_fifo.
module cau_front import cau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  in_item_t in_data,
  output logic     in_full,
  output logic     cmd_vld,
  output cmd_t     cmd,
  input  logic     cmd_take
);

  localparam int QUEUE_DEPTH = 4;

  cmd_t cls;
  logic eq;
  logic cmd_empty;

  assign eq = (in_data.a_real == in_data.b_real) && (in_data.a_imag == in_data.b_imag);

  always_comb begin
    cls.a_real = in_data.a_real;
    cls.a_imag = in_data.a_imag;
    cls.b_real = in_data.b_real;
    cls.b_imag = in_data.b_imag;
    cls.cmp    = 1'b0;
    unique case (in_data.mode)
      MODE_ADD: cls.op = OP_ADD;
      MODE_SUB: cls.op = OP_SUB;
      MODE_MUL: cls.op = OP_MUL;
      MODE_DIV: cls.op = OP_DIV;
      MODE_EQ: begin
        cls.op  = OP_CMP;
        cls.cmp = eq;
      end
      MODE_NE: begin
        cls.op  = OP_CMP;
        cls.cmp = !eq;
      end
      default: cls.op = OP_NOP;
    endcase
  end

  cau_fifo #(.T(cmd_t), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cls),
    .full  (in_full),
    .pop   (cmd_take),
    .dout  (cmd),
    .empty (cmd_empty)
  );

  assign cmd_vld = !cmd_empty;

endmodule

FILE: hw/rtl/cau_back.sv
// Back part: pipelined multiply, sum, one-bit-per-stage restoring divide
// and final clamp. Depends on cau_pkg.
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_vld,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      res_vld,
  output out_item_t res,
  input  logic      res_full
);

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int XW = 2 * W + 1;
  localparam int QB = W + FRAC_BITS;

  typedef struct packed {
    op_t           op;
    logic          cmp;
    logic          dz;
    logic          neg_re;
    logic          neg_im;
    logic [PW-1:0] den;
    logic [PW-1:0] rem_re;
    logic [PW-1:0] rem_im;
    logic [QB-1:0] low_re;
    logic [QB-1:0] low_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
  } ds_t;

  logic en;

  // Stage 1: operands.
  logic s1_vld_r;
  cmd_t s1_r;

  // Stage 2: products and part-wise sums.
  logic                 s2_vld_r;
  op_t                  s2_op_r;
  logic                 s2_cmp_r;
  logic signed [PW-1:0] ac_r, bd_r, bc_r, ad_r, cc_r, dd_r;
  logic signed [PW-1:0] ac_nxt, bd_nxt, bc_nxt, ad_nxt, cc_nxt, dd_nxt;
  logic signed [W:0]    as_re_r, as_im_r, as_re_nxt, as_im_nxt;

  // Stage 3: wide sums and divisor.
  logic                 s3_vld_r;
  op_t                  s3_op_r;
  logic                 s3_cmp_r;
  logic signed [XW-1:0] x_re_r, x_im_r, x_re_nxt, x_im_nxt;
  logic [PW-1:0]        den_r, den_nxt;

  // Divider stages; index 0 is the prepared operand set.
  logic [QB:0]   dv_vld_r;
  ds_t           st_r [QB+1];
  ds_t           st_nxt [QB+1];
  logic [XW-1:0] mag_re, mag_im;

  function automatic logic signed [XW-1:0] ext(input logic signed [PW-1:0] p);
    ext = {p[PW-1], p};
  endfunction

  function automatic logic [QB-1:0] pack_mag(input logic [XW-1:0] v);
    pack_mag = QB'({(|v[XW-1:W]), v[W-1:0]});
  endfunction

  function automatic ds_t div_step(input ds_t s);
    ds_t         n;
    logic [PW:0] t_re, t_im, dd;
    logic        ge_re, ge_im;
    n     = s;
    dd    = {1'b0, s.den};
    t_re  = {s.rem_re, s.low_re[QB-1]};
    t_im  = {s.rem_im, s.low_im[QB-1]};
    ge_re = (t_re >= dd);
    ge_im = (t_im >= dd);
    if (s.op == OP_DIV) begin
      n.rem_re = ge_re ? PW'(t_re - dd) : t_re[PW-1:0];
      n.rem_im = ge_im ? PW'(t_im - dd) : t_im[PW-1:0];
      n.low_re = s.low_re << 1;
      n.low_im = s.low_im << 1;
      n.q_re   = {s.q_re[QB-2:0], ge_re};
      n.q_im   = {s.q_im[QB-2:0], ge_im};
    end
    div_step = n;
  endfunction

  function automatic logic [W:0] clamp(input logic [QB-1:0] q, input logic neg);
    logic [W-1:0] lim, m, mm;
    logic         sat;
    lim   = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    m     = q[W-1:0];
    sat   = (|q[QB-1:W]) || (m > lim);
    mm    = sat ? lim : m;
    clamp = {sat, (neg ? W'(-mm) : mm)};
  endfunction

  assign en       = !dv_vld_r[QB] || !res_full;
  assign cmd_take = cmd_vld && en;

  assign ac_nxt = s1_r.a_real * s1_r.b_real;
  assign bd_nxt = s1_r.a_imag * s1_r.b_imag;
  assign bc_nxt = s1_r.a_imag * s1_r.b_real;
  assign ad_nxt = s1_r.a_real * s1_r.b_imag;
  assign cc_nxt = s1_r.b_real * s1_r.b_real;
  assign dd_nxt = s1_r.b_imag * s1_r.b_imag;

  always_comb begin
    if (s1_r.op == OP_SUB) begin
      as_re_nxt = {s1_r.a_real[W-1], s1_r.a_real} - {s1_r.b_real[W-1], s1_r.b_real};
      as_im_nxt = {s1_r.a_imag[W-1], s1_r.a_imag} - {s1_r.b_imag[W-1], s1_r.b_imag};
    end else begin
      as_re_nxt = {s1_r.a_real[W-1], s1_r.a_real} + {s1_r.b_real[W-1], s1_r.b_real};
      as_im_nxt = {s1_r.a_imag[W-1], s1_r.a_imag} + {s1_r.b_imag[W-1], s1_r.b_imag};
    end
  end

  always_comb begin
    den_nxt = $unsigned(cc_r) + $unsigned(dd_r);
    unique case (s2_op_r)
      OP_ADD, OP_SUB: begin
        x_re_nxt = {{(XW-W-1){as_re_r[W]}}, as_re_r};
        x_im_nxt = {{(XW-W-1){as_im_r[W]}}, as_im_r};
      end
      OP_MUL: begin
        x_re_nxt = ext(ac_r) - ext(bd_r);
        x_im_nxt = ext(bc_r) + ext(ad_r);
      end
      OP_DIV: begin
        x_re_nxt = ext(ac_r) + ext(bd_r);
        x_im_nxt = ext(bc_r) - ext(ad_r);
      end
      default: begin
        x_re_nxt = '0;
        x_im_nxt = '0;
      end
    endcase
  end

  assign mag_re = x_re_r[XW-1] ? XW'(-x_re_r) : x_re_r;
  assign mag_im = x_im_r[XW-1] ? XW'(-x_im_r) : x_im_r;

  always_comb begin
    st_nxt[0].op     = s3_op_r;
    st_nxt[0].cmp    = s3_cmp_r;
    st_nxt[0].dz     = (s3_op_r == OP_DIV) && (den_r == '0);
    st_nxt[0].neg_re = x_re_r[XW-1];
    st_nxt[0].neg_im = x_im_r[XW-1];
    st_nxt[0].den    = den_r;
    st_nxt[0].rem_re = PW'(mag_re >> W);
    st_nxt[0].rem_im = PW'(mag_im >> W);
    st_nxt[0].low_re = {mag_re[W-1:0], {FRAC_BITS{1'b0}}};
    st_nxt[0].low_im = {mag_im[W-1:0], {FRAC_BITS{1'b0}}};
    unique case (s3_op_r)
      OP_ADD, OP_SUB: begin
        st_nxt[0].q_re = pack_mag(mag_re);
        st_nxt[0].q_im = pack_mag(mag_im);
      end
      OP_MUL: begin
        st_nxt[0].q_re = pack_mag(mag_re >> FRAC_BITS);
        st_nxt[0].q_im = pack_mag(mag_im >> FRAC_BITS);
      end
      default: begin
        st_nxt[0].q_re = '0;
        st_nxt[0].q_im = '0;
      end
    endcase
    for (int k = 0; k < QB; k++) begin
      st_nxt[k+1] = div_step(st_r[k]);
    end
  end

  always_comb begin
    logic [W:0] cr, ci;
    ds_t        f;
    f   = st_r[QB];
    cr  = clamp(f.q_re, f.neg_re);
    ci  = clamp(f.q_im, f.neg_im);
    res = '0;
    unique case (f.op)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (f.dz) begin
          res.divide_by_zero = 1'b1;
        end else begin
          res.res_real  = cr[W-1:0];
          res.res_imag  = ci[W-1:0];
          res.saturated = cr[W] | ci[W];
        end
      end
      OP_CMP: res.compare_true = f.cmp;
      default: res = '0;
    endcase
  end

  assign res_vld = dv_vld_r[QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      dv_vld_r <= '0;
    end else if (en) begin
      s1_vld_r <= cmd_take;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      dv_vld_r <= {dv_vld_r[QB-1:0], s3_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= cmd;
      s2_op_r  <= s1_r.op;
      s2_cmp_r <= s1_r.cmp;
      ac_r     <= ac_nxt;
      bd_r     <= bd_nxt;
      bc_r     <= bc_nxt;
      ad_r     <= ad_nxt;
      cc_r     <= cc_nxt;
      dd_r     <= dd_nxt;
      as_re_r  <= as_re_nxt;
      as_im_r  <= as_im_nxt;
      s3_op_r  <= s2_op_r;
      s3_cmp_r <= s2_cmp_r;
      x_re_r   <= x_re_nxt;
      x_im_r   <= x_im_nxt;
      den_r    <= den_nxt;
      for (int k = 0; k <= QB; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

endmodule

FILE: hw/rtl/cau_checker.sv
// Port-level checks for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arith_unit_top.
module cau_checker import cau_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_pop,
  input out_item_t out_data,
  input logic      out_empty
);

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  a_empty_after_reset: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> out_empty)
    else $error("result present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.divide_by_zero |->
      out_data.res_real == '0 && out_data.res_imag == '0 &&
      !out_data.saturated && !out_data.compare_true)
    else $error("zero divisor result not clean");

  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.compare_true |->
      out_data.res_real == '0 && out_data.res_imag == '0 && !out_data.saturated)
    else $error("compare result not clean");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.saturated |->
      out_data.res_real == WMAX || out_data.res_real == WMIN ||
      out_data.res_imag == WMAX || out_data.res_imag == WMIN)
    else $error("saturated result not at a limit");

endmodule

bind complex_arith_unit_top cau_checker u_cau_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for complex_arith_unit_top: random and directed
// complex operands checked against a built-in predictor. Depends on cau_pkg and complex_arith_unit_top.
module testbench;
  import cau_pkg::*;

  localparam int IDLE_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  in_item_t  in_data;
  logic      in_full;
  logic      out_pop;
  out_item_t out_data;
  logic      out_empty;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  int        n_mismatch;
  int        n_accepted;
  int        idle_cycles;
  int        in_gap;
  int        out_gap;
  int        hold_cnt;
  bit        hold_done;
  bit        in_took;
  bit        out_took;

  complex_arith_unit_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_data(in_data), .in_full(in_full),
    .out_pop(out_pop), .out_data(out_data), .out_empty(out_empty)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic word_t clamp_word(input logic signed [127:0] v, inout logic sat);
    if (v > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end else if (v < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] shift_toward_zero(input logic signed [127:0] v);
    if (v < 0) return -((-v) >>> 16);
    return v >>> 16;
  endfunction

  function automatic out_item_t complex_result(input in_item_t x);
    out_item_t r;
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    logic sat;
    ar = x.a_real;
    ai = x.a_imag;
    br = x.b_real;
    bi = x.b_imag;
    r = '0;
    sat = 1'b0;
    case (x.mode)
      MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV: begin
        re = 0;
        im = 0;
        if (x.mode == MODE_ADD) begin
          re = ar + br;
          im = ai + bi;
        end else if (x.mode == MODE_SUB) begin
          re = ar - br;
          im = ai - bi;
        end else if (x.mode == MODE_MUL) begin
          re = shift_toward_zero(ar * br - ai * bi);
          im = shift_toward_zero(ai * br + ar * bi);
        end else begin
          den = br * br + bi * bi;
          if (den == 0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            re = ((ar * br + ai * bi) * 65536) / den;
            im = ((ai * br - ar * bi) * 65536) / den;
          end
        end
        r.res_real = clamp_word(re, sat);
        r.res_imag = clamp_word(im, sat);
        r.saturated = sat;
      end
      MODE_EQ: r.compare_true = (x.a_real == x.b_real) && (x.a_imag == x.b_imag);
      MODE_NE: r.compare_true = !((x.a_real == x.b_real) && (x.a_imag == x.b_imag));
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic word_t random_part();
    case ($urandom_range(0, 5))
      0: return $signed($urandom_range(0, 524288)) - 262144;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 33554432)) - 16777216;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_op(input logic [MODE_BITS-1:0] m, input word_t ar, input word_t ai,
                        input word_t br, input word_t bi);
    in_item_t x;
    x.mode = m;
    x.a_real = ar;
    x.a_imag = ai;
    x.b_real = br;
    x.b_imag = bi;
    pending_ops.push_back(x);
  endtask

  always @(posedge clk) begin
    in_took = 1'b0;
    out_took = 1'b0;
    if (rst_n && in_push && !in_full) begin
      expected_results.push_back(complex_result(in_data));
      void'(pending_ops.pop_front());
      n_accepted++;
      in_took = 1'b1;
    end
    if (rst_n && out_pop && !out_empty) begin
      out_took = 1'b1;
      if (expected_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("Unexpected result transaction: %p", out_data);
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (out_data !== e) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("Mismatch: expected %p, actual %p", e, out_data);
        end
      end
    end
    if (in_took || out_took) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("complex_arith_unit_top test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (in_push && !in_took) begin
      in_push <= 1'b1;
    end else if (in_gap > 0) begin
      in_push <= 1'b0;
      in_gap--;
    end else if (pending_ops.size() > 0) begin
      in_data <= pending_ops[0];
      in_push <= 1'b1;
      in_gap = ((n_accepted / 100) % 2 == 0) ? 0 : $urandom_range(0, 15);
    end else begin
      in_push <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!hold_done && n_accepted >= 300) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_CYCLES;
    end
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_pop <= 1'b0;
      hold_cnt--;
    end else if (out_pop && !out_took) begin
      out_pop <= 1'b1;
    end else if (out_gap > 0) begin
      out_pop <= 1'b0;
      out_gap--;
    end else begin
      out_pop <= 1'b1;
      out_gap = ((n_accepted / 150) % 2 == 1) ? 0 : $urandom_range(0, 15);
    end
  end

  initial begin
    in_item_t x;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_data = '0;
    out_pop = 1'b0;
    n_mismatch = 0;
    n_accepted = 0;
    idle_cycles = 0;
    in_gap = 0;
    out_gap = 0;
    hold_cnt = 0;
    hold_done = 1'b0;

    add_op(MODE_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    add_op(MODE_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    add_op(MODE_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    add_op(MODE_SUB, 32'sh00010000, 32'shffff0000, 32'sh00000000, 32'shffffffff);
    add_op(MODE_MUL, 32'sh00020000, 32'sh00030000, 32'sh00040000, 32'shfffb0000);
    add_op(MODE_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    add_op(MODE_MUL, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    add_op(MODE_MUL, 32'shffffffff, 32'sh00000001, 32'sh00000001, 32'sh00000001);
    add_op(MODE_DIV, 32'sh00010000, 32'sh00020000, 32'sh00000000, 32'sh00000000);
    add_op(MODE_DIV, 32'sh00050000, 32'shfffd0000, 32'sh00020000, 32'sh00010000);
    add_op(MODE_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh00000001, 32'sh00000000);
    add_op(MODE_DIV, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    add_op(MODE_DIV, 32'shffffffff, 32'sh00000001, 32'sh7fffffff, 32'sh80000000);
    add_op(MODE_EQ, 32'sh12345678, 32'sh80000000, 32'sh12345678, 32'sh80000000);
    add_op(MODE_EQ, 32'sh12345678, 32'sh80000000, 32'sh12345679, 32'sh80000000);
    add_op(MODE_NE, 32'sh7fffffff, 32'sh00000000, 32'sh7fffffff, 32'sh00000000);
    add_op(MODE_NE, 32'sh7fffffff, 32'sh00000000, 32'sh7fffffff, 32'sh00000001);
    add_op(3'd6, 32'sh7fffffff, 32'sh80000000, 32'sh00010000, 32'sh00000000);
    add_op(3'd7, 32'shffffffff, 32'shffffffff, 32'shffffffff, 32'shffffffff);
    add_op(MODE_ADD, 32'sh00000000, 32'sh00000000, 32'sh00000000, 32'sh00000000);
    for (int i = 0; i < 950; i++) begin
      x.mode = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) :
               3'($urandom_range(0, 5));
      x.a_real = random_part();
      x.a_imag = random_part();
      x.b_real = random_part();
      x.b_imag = random_part();
      if (x.mode >= MODE_EQ && $urandom_range(0, 1)) begin
        x.b_real = x.a_real;
        x.b_imag = x.a_imag;
        if ($urandom_range(0, 1)) x.b_imag[$urandom_range(0, 31)] ^= 1'b1;
      end
      if (x.mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
        x.b_real = '0;
        x.b_imag = '0;
      end
      pending_ops.push_back(x);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (pending_ops.size() == 0 && expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (n_mismatch == 0 && expected_results.size() == 0) begin
      $display("complex_arith_unit_top test passed");
    end else begin
      $display("complex_arith_unit_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_fifo.sv
hw/rtl/cau_front.sv
hw/rtl/cau_back.sv
hw/rtl/complex_arith_unit_top.sv
hw/rtl/cau_checker.sv
bench/testbench.sv
